FILE: rtl/core/hbac_pkg.sv
package hbac_pkg;

  localparam int unsigned VOLT_BITS_DEF = 12;
  localparam int unsigned STEP_W        = 3;
  localparam int unsigned BUTTON_W      = 2;
  localparam int unsigned PHASE_W       = 2;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned OUT_DATA_W    = 8;

  localparam int BASE_TOL      = 35;
  localparam int HOOK_MIN_RST  = 0;
  localparam int HOOK_MAX_RST  = 135;
  localparam int FWD_MIN_RST   = 136;
  localparam int FWD_MAX_RST   = 350;
  localparam int BACK_MIN_RST  = 351;
  localparam int BACK_MAX_RST  = 700;

  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [PHASE_W-1:0]    phase_t;
  typedef logic [BUTTON_W-1:0]   button_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam logic OP_PRESS = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam step_t STEP_CHECK  = 3'd0;
  localparam step_t STEP_TOL    = 3'd1;
  localparam step_t STEP_REC    = 3'd2;
  localparam step_t STEP_ADJ    = 3'd3;
  localparam step_t STEP_REPORT = 3'd4;

  localparam phase_t PH_NONE = 2'd0;
  localparam phase_t PH_LOW  = 2'd1;
  localparam phase_t PH_BOTH = 2'd2;

  localparam button_t BTN_NONE = 2'd0;
  localparam button_t BTN_HOOK = 2'd1;
  localparam button_t BTN_FWD  = 2'd2;
  localparam button_t BTN_BACK = 2'd3;

  localparam cfg_addr_t REG_ENABLE      = 3'd0;
  localparam cfg_addr_t REG_HOOK_MIN    = 3'd1;
  localparam cfg_addr_t REG_HOOK_MAX    = 3'd2;
  localparam cfg_addr_t REG_FWD_MIN     = 3'd3;
  localparam cfg_addr_t REG_FWD_MAX_INI = 3'd4;
  localparam cfg_addr_t REG_BACK_MIN_INI = 3'd5;
  localparam cfg_addr_t REG_BACK_MAX    = 3'd6;

endpackage

FILE: rtl/core/hbac_learn.sv
module hbac_learn #(
  parameter int unsigned VOLT_BITS = hbac_pkg::VOLT_BITS_DEF,
  localparam int unsigned REC_W = VOLT_BITS + 1,
  localparam int unsigned TOL_W = VOLT_BITS + 2
) (
  input  logic                    op,
  input  hbac_pkg::step_t         step,
  input  logic [VOLT_BITS-1:0]    voltage,
  input  logic                    enable,
  input  logic [VOLT_BITS-1:0]    hook_min,
  input  logic [VOLT_BITS-1:0]    hook_max,
  input  logic [VOLT_BITS-1:0]    forward_min,
  input  logic [VOLT_BITS-1:0]    back_max,
  input  hbac_pkg::phase_t        phase,
  input  logic signed [REC_W-1:0] low_rec,
  input  logic signed [REC_W-1:0] high_rec,
  input  logic signed [TOL_W-1:0] low_tol,
  input  logic signed [TOL_W-1:0] high_tol,
  input  logic signed [TOL_W-1:0] gap,
  input  logic [VOLT_BITS-1:0]    fwd_max,
  input  logic [VOLT_BITS-1:0]    back_min,
  output hbac_pkg::phase_t        phase_nxt,
  output logic signed [REC_W-1:0] low_rec_nxt,
  output logic signed [REC_W-1:0] high_rec_nxt,
  output logic signed [TOL_W-1:0] low_tol_nxt,
  output logic signed [TOL_W-1:0] high_tol_nxt,
  output logic signed [TOL_W-1:0] gap_nxt,
  output logic [VOLT_BITS-1:0]    fwd_max_nxt,
  output logic [VOLT_BITS-1:0]    back_min_nxt,
  output logic                    has_result,
  output hbac_pkg::button_t       button
);

  localparam logic signed [TOL_W-1:0] BASE_TOL_V = TOL_W'(hbac_pkg::BASE_TOL);
  localparam logic signed [REC_W-1:0] EMPTY_REC  = {REC_W{1'b1}};

  logic signed [TOL_W-1:0] v_s, hook_max_s, lo_s, hi_s;
  logic signed [TOL_W-1:0] diff_lo, diff_hi, abs_lo, abs_hi;
  logic signed [TOL_W-1:0] lo1, hi1, rec_span, gap1, lt_a, lt_b, lt, ht, sum, mid;
  logic                    go, in_tol, do_record, rec_ok, upd_tol, do_adj;
  hbac_pkg::step_t         start;
  hbac_pkg::phase_t        ph1;
  logic [VOLT_BITS-1:0]    fmax1, bmin1, fmax_use, bmin_use;

  always_comb begin
    v_s        = $signed({2'b00, voltage});
    hook_max_s = $signed({2'b00, hook_max});
    lo_s       = TOL_W'(low_rec);
    hi_s       = TOL_W'(high_rec);

    go = (op == hbac_pkg::OP_PRESS) && enable && (voltage <= back_max)
         && (step <= hbac_pkg::STEP_REPORT);

    diff_lo = v_s - lo_s;
    diff_hi = v_s - hi_s;
    abs_lo  = (diff_lo < 0) ? -diff_lo : diff_lo;
    abs_hi  = (diff_hi < 0) ? -diff_hi : diff_hi;
    in_tol  = ((phase != hbac_pkg::PH_NONE) && (abs_lo < low_tol))
              || ((phase >= hbac_pkg::PH_BOTH) && (abs_hi < high_tol));

    if (step == hbac_pkg::STEP_CHECK) begin
      start = (phase == hbac_pkg::PH_NONE) ? hbac_pkg::STEP_REC : hbac_pkg::STEP_TOL;
    end else begin
      start = step;
    end
    do_record = go && ((start == hbac_pkg::STEP_REC)
                       || ((start == hbac_pkg::STEP_TOL) && !in_tol));
    rec_ok    = do_record && (voltage >= hook_max);

    lo1     = lo_s;
    hi1     = hi_s;
    ph1     = phase;
    upd_tol = 1'b0;
    if (rec_ok) begin
      case (phase)
        hbac_pkg::PH_NONE: begin
          lo1 = v_s;
          ph1 = hbac_pkg::PH_LOW;
        end
        hbac_pkg::PH_LOW: begin
          if (v_s > lo_s) begin
            hi1 = v_s;
          end else begin
            hi1 = lo_s;
            lo1 = v_s;
          end
          ph1     = hbac_pkg::PH_BOTH;
          upd_tol = 1'b1;
        end
        default: begin
          if (v_s < lo_s) begin
            lo1 = v_s;
          end else if (v_s > hi_s) begin
            hi1 = v_s;
          end
          upd_tol = 1'b1;
        end
      endcase
    end

    rec_span = hi1 - lo1;
    gap1 = (upd_tol && (rec_span > gap)) ? rec_span : gap;
    lt_a = gap1 >>> 1;
    lt_b = (lo1 - hook_max_s) >>> 1;
    lt   = (lt_b < lt_a) ? lt_b : lt_a;
    ht   = gap1 - lt;

    do_adj = go && ((start == hbac_pkg::STEP_ADJ)
                    || (do_record && (ph1 >= hbac_pkg::PH_BOTH)));
    sum    = lo1 + hi1;
    mid    = (sum < 0) ? '0 : (sum >>> 1);
    fmax1  = mid[VOLT_BITS-1:0];
    bmin1  = (&fmax1) ? fmax1 : fmax1 + 1'b1;

    fmax_use = do_adj ? fmax1 : fwd_max;
    bmin_use = do_adj ? bmin1 : back_min;

    if ((voltage >= hook_min) && (voltage <= hook_max)) begin
      button = hbac_pkg::BTN_HOOK;
    end else if ((voltage >= forward_min) && (voltage <= fmax_use)) begin
      button = hbac_pkg::BTN_FWD;
    end else if ((voltage >= bmin_use) && (voltage <= back_max)) begin
      button = hbac_pkg::BTN_BACK;
    end else begin
      button = hbac_pkg::BTN_NONE;
    end

    has_result   = go;
    fwd_max_nxt  = fmax_use;
    back_min_nxt = bmin_use;
    gap_nxt      = gap1;
    if (op == hbac_pkg::OP_CLEAR) begin
      phase_nxt    = hbac_pkg::PH_NONE;
      low_rec_nxt  = EMPTY_REC;
      high_rec_nxt = EMPTY_REC;
      low_tol_nxt  = BASE_TOL_V;
      high_tol_nxt = BASE_TOL_V;
    end else begin
      phase_nxt    = ph1;
      low_rec_nxt  = REC_W'(lo1);
      high_rec_nxt = REC_W'(hi1);
      low_tol_nxt  = upd_tol ? lt : low_tol;
      high_tol_nxt = upd_tol ? ht : high_tol;
    end
  end

endmodule

FILE: rtl/core/headset_button_adaptive_classifier_core.sv
// Headset button classifier with learned forward/back split. Takes one word per
// cycle unless the output stalls; each word passes an input register, one pass of
// compare-and-update logic that also writes the learned records, and an output
// register. Press words that are disabled, above back_max or carry a start step
// beyond report, and all clear words, give no output word. Configuration writes
// take effect on the next clock edge.
module headset_button_adaptive_classifier_core #(
  parameter int unsigned VOLT_BITS = hbac_pkg::VOLT_BITS_DEF,
  localparam int unsigned IN_DATA_W = ((hbac_pkg::STEP_W + VOLT_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DATA_W-1:0]            in_tdata,   // entry_step, voltage
  input  logic                            in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hbac_pkg::OUT_DATA_W-1:0] out_tdata,  // button
  input  logic                            cfg_we,
  input  hbac_pkg::cfg_addr_t             cfg_addr,
  input  logic [VOLT_BITS-1:0]            cfg_wdata
);

  localparam int unsigned REC_W = VOLT_BITS + 1;
  localparam int unsigned TOL_W = VOLT_BITS + 2;
  localparam int unsigned SW    = hbac_pkg::STEP_W;

  logic                    s1_valid_r, s1_op_r, s1_adv;
  hbac_pkg::step_t         s1_step_r;
  logic [VOLT_BITS-1:0]    s1_volt_r;
  logic                    out_valid_r;
  hbac_pkg::button_t       out_button_r;

  logic                    enable_r;
  logic [VOLT_BITS-1:0]    hook_min_r, hook_max_r, forward_min_r, back_max_r;
  logic [VOLT_BITS-1:0]    fwd_max_r, back_min_r;
  hbac_pkg::phase_t        phase_r;
  logic signed [REC_W-1:0] low_rec_r, high_rec_r;
  logic signed [TOL_W-1:0] low_tol_r, high_tol_r, gap_r;

  hbac_pkg::phase_t        phase_nxt;
  logic signed [REC_W-1:0] low_rec_nxt, high_rec_nxt;
  logic signed [TOL_W-1:0] low_tol_nxt, high_tol_nxt, gap_nxt;
  logic [VOLT_BITS-1:0]    fwd_max_nxt, back_min_nxt;
  logic                    has_result;
  hbac_pkg::button_t       button;

  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = hbac_pkg::OUT_DATA_W'(out_button_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_step_r <= in_tdata[SW-1:0];
      s1_volt_r <= in_tdata[SW+VOLT_BITS-1:SW];
    end
  end

  hbac_learn #(
    .VOLT_BITS (VOLT_BITS)
  ) u_learn (
    .op           (s1_op_r),
    .step         (s1_step_r),
    .voltage      (s1_volt_r),
    .enable       (enable_r),
    .hook_min     (hook_min_r),
    .hook_max     (hook_max_r),
    .forward_min  (forward_min_r),
    .back_max     (back_max_r),
    .phase        (phase_r),
    .low_rec      (low_rec_r),
    .high_rec     (high_rec_r),
    .low_tol      (low_tol_r),
    .high_tol     (high_tol_r),
    .gap          (gap_r),
    .fwd_max      (fwd_max_r),
    .back_min     (back_min_r),
    .phase_nxt    (phase_nxt),
    .low_rec_nxt  (low_rec_nxt),
    .high_rec_nxt (high_rec_nxt),
    .low_tol_nxt  (low_tol_nxt),
    .high_tol_nxt (high_tol_nxt),
    .gap_nxt      (gap_nxt),
    .fwd_max_nxt  (fwd_max_nxt),
    .back_min_nxt (back_min_nxt),
    .has_result   (has_result),
    .button       (button)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= has_result;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_button_r <= button;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      hook_min_r    <= VOLT_BITS'(hbac_pkg::HOOK_MIN_RST);
      hook_max_r    <= VOLT_BITS'(hbac_pkg::HOOK_MAX_RST);
      forward_min_r <= VOLT_BITS'(hbac_pkg::FWD_MIN_RST);
      back_max_r    <= VOLT_BITS'(hbac_pkg::BACK_MAX_RST);
      fwd_max_r     <= VOLT_BITS'(hbac_pkg::FWD_MAX_RST);
      back_min_r    <= VOLT_BITS'(hbac_pkg::BACK_MIN_RST);
      phase_r       <= hbac_pkg::PH_NONE;
      low_rec_r     <= {REC_W{1'b1}};
      high_rec_r    <= {REC_W{1'b1}};
      low_tol_r     <= TOL_W'(hbac_pkg::BASE_TOL);
      high_tol_r    <= TOL_W'(hbac_pkg::BASE_TOL);
      gap_r         <= TOL_W'(hbac_pkg::BASE_TOL);
    end else begin
      if (s1_adv) begin
        phase_r    <= phase_nxt;
        low_rec_r  <= low_rec_nxt;
        high_rec_r <= high_rec_nxt;
        low_tol_r  <= low_tol_nxt;
        high_tol_r <= high_tol_nxt;
        gap_r      <= gap_nxt;
        fwd_max_r  <= fwd_max_nxt;
        back_min_r <= back_min_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          hbac_pkg::REG_ENABLE:       enable_r      <= cfg_wdata[0];
          hbac_pkg::REG_HOOK_MIN:     hook_min_r    <= cfg_wdata;
          hbac_pkg::REG_HOOK_MAX:     hook_max_r    <= cfg_wdata;
          hbac_pkg::REG_FWD_MIN:      forward_min_r <= cfg_wdata;
          hbac_pkg::REG_FWD_MAX_INI:  fwd_max_r     <= cfg_wdata;
          hbac_pkg::REG_BACK_MIN_INI: back_min_r    <= cfg_wdata;
          hbac_pkg::REG_BACK_MAX:     back_max_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  a_low_known: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != hbac_pkg::PH_NONE) |-> !low_rec_r[REC_W-1])
    else $error("low record empty while phase says known");

  a_rec_order: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hbac_pkg::PH_BOTH) |-> (high_rec_r >= low_rec_r))
    else $error("high record below low record");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_op_r == hbac_pkg::OP_CLEAR)) |=> (phase_r == hbac_pkg::PH_NONE))
    else $error("clear word did not reset learn phase");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("output word appeared without a word leaving the input register");

endmodule

FILE: tb/headset_button_adaptive_classifier_core_tb.sv
`timescale 1ns / 100ps

module headset_button_adaptive_classifier_core_tb;

  localparam int VOLT_BITS = hbac_pkg::VOLT_BITS_DEF;
  localparam int VOLT_TOP  = (1 << VOLT_BITS) - 1;
  localparam int IN_W      = ((hbac_pkg::STEP_W + VOLT_BITS + 7) / 8) * 8;
  localparam int N_DIR     = 32;
  localparam int SETTLE_CYCLES = 8;

  localparam hbac_pkg::step_t STEP_PAST_REPORT = hbac_pkg::STEP_REPORT + 3'd1;
  localparam hbac_pkg::step_t STEP_TOP         = '1;

  typedef struct packed {
    logic                 is_reg;
    logic                 op;
    hbac_pkg::step_t      step;
    hbac_pkg::cfg_addr_t  addr;
    logic [VOLT_BITS-1:0] val;
    logic                 typed;
    logic                 has_res;
    hbac_pkg::button_t    btn;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // entry_step, voltage
  logic                 in_tuser = 1'b0; // op
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [hbac_pkg::OUT_DATA_W-1:0] out_tdata;  // button
  logic                 cfg_we = 1'b0;
  hbac_pkg::cfg_addr_t  cfg_addr = hbac_pkg::REG_ENABLE;
  logic [VOLT_BITS-1:0] cfg_wdata = '0;

  headset_button_adaptive_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // classifier model state
  bit     en_m = 1'b0;
  int     hk_min = hbac_pkg::HOOK_MIN_RST, hk_max = hbac_pkg::HOOK_MAX_RST;
  int     fw_min = hbac_pkg::FWD_MIN_RST;
  int     bk_max = hbac_pkg::BACK_MAX_RST;
  int     fwd_max_w = hbac_pkg::FWD_MAX_RST, back_min_w = hbac_pkg::BACK_MIN_RST;
  int     rec_lo = -1, rec_hi = -1;
  int     tol_lo = hbac_pkg::BASE_TOL, tol_hi = hbac_pkg::BASE_TOL;
  int     gap_w = hbac_pkg::BASE_TOL;
  hbac_pkg::phase_t phase = hbac_pkg::PH_NONE;

  hbac_pkg::button_t pending_buttons[$];
  hbac_pkg::button_t want;
  int errors = 0, n_words = 0, n_results = 0, n_clears = 0, n_settings = 0;
  int idle_pct = 25, stall_pct = 73;
  dir_row_t dir_tab [N_DIR];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int volt_gap(input int a, input int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic bit learn_and_classify(input logic op, input hbac_pkg::step_t st,
                                            input int v, output hbac_pkg::button_t btn);
    hbac_pkg::step_t s;
    int    lt, t, d, sum, mid;
    bit    hit;
    btn = hbac_pkg::BTN_NONE;
    if (op == hbac_pkg::OP_CLEAR) begin
      rec_lo = -1;
      rec_hi = -1;
      tol_lo = hbac_pkg::BASE_TOL;
      tol_hi = hbac_pkg::BASE_TOL;
      phase  = hbac_pkg::PH_NONE;
      return 1'b0;
    end
    if (!en_m || v > bk_max || st > hbac_pkg::STEP_REPORT)
      return 1'b0;
    s = st;
    if (s == hbac_pkg::STEP_CHECK)
      s = (phase == hbac_pkg::PH_NONE) ? hbac_pkg::STEP_REC : hbac_pkg::STEP_TOL;
    if (s == hbac_pkg::STEP_TOL) begin
      hit = (phase != hbac_pkg::PH_NONE && volt_gap(v, rec_lo) < tol_lo) ||
            (phase == hbac_pkg::PH_BOTH && volt_gap(v, rec_hi) < tol_hi);
      s = hit ? hbac_pkg::STEP_REPORT : hbac_pkg::STEP_REC;
    end
    if (s == hbac_pkg::STEP_REC) begin
      if (v >= hk_max) begin
        case (phase)
          hbac_pkg::PH_NONE: begin
            rec_lo = v;
            phase  = hbac_pkg::PH_LOW;
          end
          hbac_pkg::PH_LOW: begin
            if (v > rec_lo) begin
              rec_hi = v;
            end else begin
              rec_hi = rec_lo;
              rec_lo = v;
            end
            phase = hbac_pkg::PH_BOTH;
          end
          default: begin
            if (v < rec_lo) rec_lo = v;
            else if (v > rec_hi) rec_hi = v;
          end
        endcase
        if (phase == hbac_pkg::PH_BOTH) begin
          if (rec_hi - rec_lo > gap_w) gap_w = rec_hi - rec_lo;
          lt = gap_w / 2;
          d  = rec_lo - hk_max;
          // round toward minus infinity
          t  = d >= 0 ? d / 2 : -((1 - d) / 2);
          if (t < lt) lt = t;
          tol_lo = lt;
          tol_hi = gap_w - lt;
        end
      end
      s = (phase == hbac_pkg::PH_BOTH) ? hbac_pkg::STEP_ADJ : hbac_pkg::STEP_REPORT;
    end
    if (s == hbac_pkg::STEP_ADJ) begin
      sum = rec_lo + rec_hi;
      mid = sum < 0 ? 0 : sum / 2;
      if (mid > VOLT_TOP) mid = VOLT_TOP;
      fwd_max_w  = mid;
      back_min_w = mid < VOLT_TOP ? mid + 1 : VOLT_TOP;
    end
    if (v >= hk_min && v <= hk_max) btn = hbac_pkg::BTN_HOOK;
    else if (v >= fw_min && v <= fwd_max_w) btn = hbac_pkg::BTN_FWD;
    else if (v >= back_min_w && v <= bk_max) btn = hbac_pkg::BTN_BACK;
    return 1'b1;
  endfunction

  function automatic dir_row_t press_row(input hbac_pkg::step_t st, input int v);
    return '{1'b0, hbac_pkg::OP_PRESS, st, hbac_pkg::REG_ENABLE, VOLT_BITS'(v), 1'b0, 1'b0,
             hbac_pkg::BTN_NONE};
  endfunction

  function automatic dir_row_t known_row(input logic op, input hbac_pkg::step_t st,
                                         input int v, input logic has,
                                         input hbac_pkg::button_t btn);
    return '{1'b0, op, st, hbac_pkg::REG_ENABLE, VOLT_BITS'(v), 1'b1, has, btn};
  endfunction

  function automatic dir_row_t reg_row(input hbac_pkg::cfg_addr_t a, input int v);
    return '{1'b1, hbac_pkg::OP_PRESS, hbac_pkg::STEP_CHECK, a, VOLT_BITS'(v), 1'b0, 1'b0,
             hbac_pkg::BTN_NONE};
  endfunction

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_buttons.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_buttons.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_buttons.size()));
      pending_buttons.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input hbac_pkg::cfg_addr_t a, input logic [VOLT_BITS-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    case (a)
      hbac_pkg::REG_ENABLE:       en_m = d[0];
      hbac_pkg::REG_HOOK_MIN:     hk_min = int'(d);
      hbac_pkg::REG_HOOK_MAX:     hk_max = int'(d);
      hbac_pkg::REG_FWD_MIN:      fw_min = int'(d);
      hbac_pkg::REG_FWD_MAX_INI:  fwd_max_w = int'(d);
      hbac_pkg::REG_BACK_MIN_INI: back_min_w = int'(d);
      hbac_pkg::REG_BACK_MAX:     bk_max = int'(d);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic en, input int hmin, hmax, fmin, fmi, bmi, bmax);
    settle();
    set_reg(hbac_pkg::REG_ENABLE, {(VOLT_BITS-1)'($urandom), en});
    set_reg(hbac_pkg::REG_HOOK_MIN, VOLT_BITS'(hmin));
    set_reg(hbac_pkg::REG_HOOK_MAX, VOLT_BITS'(hmax));
    set_reg(hbac_pkg::REG_FWD_MIN, VOLT_BITS'(fmin));
    set_reg(hbac_pkg::REG_FWD_MAX_INI, VOLT_BITS'(fmi));
    set_reg(hbac_pkg::REG_BACK_MIN_INI, VOLT_BITS'(bmi));
    set_reg(hbac_pkg::REG_BACK_MAX, VOLT_BITS'(bmax));
    n_settings++;
  endtask

  task automatic random_setting();
    int hmax, fmi;
    hmax = $urandom_range(600, 100);
    fmi  = $urandom_range(2000, hmax + 1);
    apply_setting(1'b1, $urandom_range(100, 0), hmax, hmax + 1, fmi, fmi + 1,
                  $urandom_range(VOLT_TOP, 2000));
  endtask

  task automatic put_word(input logic op, input hbac_pkg::step_t st,
                          input logic [VOLT_BITS-1:0] v, input logic typed,
                          input logic has, input hbac_pkg::button_t btn);
    hbac_pkg::button_t b;
    bit      got;
    if (n_words < 520) begin
      idle_pct  = 25;
      stall_pct = 73;
    end else if (n_words < 1040) begin
      idle_pct  = 73;
      stall_pct = 25;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({v, st});
    do @(posedge clk); while (!in_tready);
    n_words++;
    if (op == hbac_pkg::OP_CLEAR) n_clears++;
    got = learn_and_classify(op, st, int'(v), b);
    if (typed) begin
      got = has;
      b   = btn;
    end
    if (got) pending_buttons.push_back(b);
  endtask

  task automatic run_phase(input int n);
    logic  op;
    hbac_pkg::step_t st;
    int    v, r;
    for (int i = 0; i < n; i++) begin
      // hold off until the pipe is empty now and then
      if ($urandom_range(99) == 0) settle();
      op = ($urandom_range(99) < 5) ? hbac_pkg::OP_CLEAR : hbac_pkg::OP_PRESS;
      r  = $urandom_range(99);
      if (r < 60) st = hbac_pkg::STEP_CHECK;
      else if (r < 90)
        st = hbac_pkg::step_t'($urandom_range(hbac_pkg::STEP_REPORT, hbac_pkg::STEP_CHECK));
      else st = hbac_pkg::step_t'($urandom_range(STEP_TOP, STEP_PAST_REPORT));
      r = $urandom_range(99);
      if (r < 85 && r >= 65 && phase != hbac_pkg::PH_NONE) begin
        v = (phase == hbac_pkg::PH_BOTH && $urandom_range(1)) ? rec_hi : rec_lo;
        v = v + $urandom_range(100) - 50;
        if (v < 0) v = 0;
        if (v > VOLT_TOP) v = VOLT_TOP;
      end else if (r < 85) begin
        v = $urandom_range(bk_max, 0);
      end else begin
        v = $urandom_range(VOLT_TOP, 0);
      end
      put_word(op, st, VOLT_BITS'(v), 1'b0, 1'b0, hbac_pkg::BTN_NONE);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_buttons.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %0h", out_tdata));
      end else begin
        want = pending_buttons.pop_front();
        n_results++;
        if (out_tdata !== hbac_pkg::OUT_DATA_W'(want))
          flag_mismatch($sformatf("button got %0h want %0h", out_tdata, want));
      end
    end
  end

  initial begin
    dir_tab = '{
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_CHECK, 200, 1'b0, hbac_pkg::BTN_NONE),
      known_row(hbac_pkg::OP_CLEAR, hbac_pkg::STEP_CHECK, 0, 1'b0, hbac_pkg::BTN_NONE),
      reg_row(hbac_pkg::REG_ENABLE, 1),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 0, 1'b1, hbac_pkg::BTN_HOOK),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 135, 1'b1, hbac_pkg::BTN_HOOK),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 136, 1'b1, hbac_pkg::BTN_FWD),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 350, 1'b1, hbac_pkg::BTN_FWD),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 351, 1'b1, hbac_pkg::BTN_BACK),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 700, 1'b1, hbac_pkg::BTN_BACK),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 701, 1'b0, hbac_pkg::BTN_NONE),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, VOLT_TOP, 1'b0,
                hbac_pkg::BTN_NONE),
      known_row(hbac_pkg::OP_PRESS, STEP_PAST_REPORT, 200, 1'b0, hbac_pkg::BTN_NONE),
      known_row(hbac_pkg::OP_PRESS, STEP_TOP, 200, 1'b0, hbac_pkg::BTN_NONE),
      known_row(hbac_pkg::OP_CLEAR, STEP_TOP, VOLT_TOP, 1'b0, hbac_pkg::BTN_NONE),
      press_row(hbac_pkg::STEP_CHECK, 200),
      press_row(hbac_pkg::STEP_CHECK, 600),
      press_row(hbac_pkg::STEP_TOL, 210),
      press_row(hbac_pkg::STEP_REC, 100),
      press_row(hbac_pkg::STEP_ADJ, 450),
      reg_row(hbac_pkg::REG_HOOK_MAX, 300),
      press_row(hbac_pkg::STEP_REC, 650),
      press_row(hbac_pkg::STEP_TOL, 200),
      press_row(hbac_pkg::STEP_CHECK, 250),
      known_row(hbac_pkg::OP_CLEAR, hbac_pkg::STEP_CHECK, 0, 1'b0, hbac_pkg::BTN_NONE),
      press_row(hbac_pkg::STEP_ADJ, 300),
      reg_row(hbac_pkg::REG_HOOK_MAX, 0),
      reg_row(hbac_pkg::REG_BACK_MAX, VOLT_TOP),
      press_row(hbac_pkg::STEP_CHECK, VOLT_TOP),
      press_row(hbac_pkg::STEP_REC, VOLT_TOP),
      press_row(hbac_pkg::STEP_REPORT, VOLT_TOP - 1),
      reg_row(hbac_pkg::REG_ENABLE, 0),
      known_row(hbac_pkg::OP_PRESS, hbac_pkg::STEP_REPORT, 100, 1'b0, hbac_pkg::BTN_NONE)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        settle();
        set_reg(dir_tab[i].addr, dir_tab[i].val);
      end else begin
        put_word(dir_tab[i].op, dir_tab[i].step, dir_tab[i].val, dir_tab[i].typed,
                 dir_tab[i].has_res, dir_tab[i].btn);
      end
    end

    apply_setting(1'b1, hbac_pkg::HOOK_MIN_RST, hbac_pkg::HOOK_MAX_RST,
                  hbac_pkg::FWD_MIN_RST, hbac_pkg::FWD_MAX_RST,
                  hbac_pkg::BACK_MIN_RST, hbac_pkg::BACK_MAX_RST);
    run_phase(380);
    apply_setting(1'b1, 0, 0, 0, VOLT_TOP, 0, VOLT_TOP);
    run_phase(380);
    apply_setting(1'b1, VOLT_TOP, VOLT_TOP, VOLT_TOP, 0, VOLT_TOP, 0);
    run_phase(80);
    random_setting();
    run_phase(380);
    settle();
    set_reg(hbac_pkg::REG_ENABLE, {(VOLT_BITS-1)'($urandom), 1'b0});
    run_phase(40);
    random_setting();
    run_phase(300);
    settle();

    $display("Sent %0d words (%0d clears) over %0d threshold settings.",
             n_words, n_clears, n_settings);
    $display("Checked %0d button results, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("headset_button_adaptive_classifier_core_tb passed");
    end else begin
      $display("headset_button_adaptive_classifier_core_tb failed");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("Timeout with %0d results outstanding.", pending_buttons.size());
    $display("headset_button_adaptive_classifier_core_tb failed");
    $finish;
  end

endmodule
